FILE: src/itp_pkg.sv
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_LPAREN = 3'd1;
  localparam logic [2:0] OP_PLUS   = 3'd2;
  localparam logic [2:0] OP_MINUS  = 3'd3;
  localparam logic [2:0] OP_TIMES  = 3'd4;
  localparam logic [2:0] OP_DIVIDE = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BRACES   = 3'd2;
  localparam logic [2:0] ST_SPACES   = 3'd3;
  localparam logic [2:0] ST_OPERANDS = 3'd4;
  localparam logic [2:0] ST_ILLEGAL  = 3'd5;
  localparam logic [2:0] ST_OVERFLOW = 3'd6;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_TIMES  = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DIVIDE = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_expression;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_status;
    logic [2:0] status_code;
    logic       last_of_run;
  } out_t;

  typedef enum logic [2:0] {
    CL_SPACE,
    CL_DIGIT,
    CL_LPAREN,
    CL_RPAREN,
    CL_OP,
    CL_ILLEGAL
  } char_class_t;

  typedef enum logic [1:0] {
    EM_CHAR,
    EM_TOP,
    EM_SPACE,
    EM_STATUS
  } emit_sel_t;

  typedef struct packed {
    logic       load_in;
    logic       emit;
    emit_sel_t  emit_sel;
    logic       flush;
    logic       push;
    logic       push_lparen;
    logic       pop;
    logic       set_err;
    logic [2:0] err_code;
    logic       clear_all;
    logic       fl_space;
    logic       fl_digit;
    logic       fl_nondigit;
    logic       clr_pending;
    logic       set_pending;
  } cmd_t;

  typedef struct packed {
    char_class_t cls;
    logic        is_end;
    logic        err_zero;
    logic        dts;
    logic        pending;
    logic        seen;
    logic        stack_empty;
    logic        stack_full;
    logic        top_lparen;
    logic        pop_ok;
    logic        can_emit;
    logic        hold_valid;
  } sts_t;

  function automatic logic [7:0] code_char(input logic [2:0] code);
    logic [7:0] ch;
    case (code)
      OP_LPAREN: ch = CH_LPAREN;
      OP_PLUS:   ch = CH_PLUS;
      OP_MINUS:  ch = CH_MINUS;
      OP_TIMES:  ch = CH_TIMES;
      OP_DIVIDE: ch = CH_DIVIDE;
      default:   ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_high(input logic [2:0] code);
    return (code == OP_TIMES) || (code == OP_DIVIDE);
  endfunction

endpackage

FILE: src/itp_dp.sv
module itp_dp (
  input  logic               clk,
  input  logic               rst,
  input  itp_pkg::in_t       chr_data,
  input  logic               pfx_ready,
  output logic               pfx_valid,
  output itp_pkg::out_t      pfx_data,
  input  itp_pkg::cmd_t      cmd,
  output itp_pkg::sts_t      sts
);

  itp_pkg::in_t                    in_reg;
  logic [2:0]                      stack [itp_pkg::STACK_DEPTH];
  logic [itp_pkg::CNT_W-1:0]       count;
  logic [itp_pkg::CNT_W-1:0]       count_m1;
  logic [itp_pkg::IDX_W-1:0]       top_idx;
  logic [2:0]                      top_code;
  logic [2:0]                      in_code;
  logic [2:0]                      push_code;
  logic                            seen;
  logic                            dts;
  logic                            after_digit;
  logic                            pending;
  logic [2:0]                      err;
  logic [2:0]                      final_code;
  logic                            hold_valid;
  itp_pkg::out_t                   hold;
  itp_pkg::out_t                   emit_item;
  itp_pkg::char_class_t            cls;
  logic                            out_free;

  assign count_m1 = count - 1'b1;
  assign top_idx  = count_m1[itp_pkg::IDX_W-1:0];
  assign top_code = stack[top_idx];
  assign out_free = !pfx_valid || pfx_ready;

  always_comb begin
    in_code = itp_pkg::OP_NONE;
    case (in_reg.in_char)
      itp_pkg::CH_SPACE:  cls = itp_pkg::CL_SPACE;
      itp_pkg::CH_LPAREN: cls = itp_pkg::CL_LPAREN;
      itp_pkg::CH_RPAREN: cls = itp_pkg::CL_RPAREN;
      itp_pkg::CH_PLUS: begin
        cls = itp_pkg::CL_OP;
        in_code = itp_pkg::OP_PLUS;
      end
      itp_pkg::CH_MINUS: begin
        cls = itp_pkg::CL_OP;
        in_code = itp_pkg::OP_MINUS;
      end
      itp_pkg::CH_TIMES: begin
        cls = itp_pkg::CL_OP;
        in_code = itp_pkg::OP_TIMES;
      end
      itp_pkg::CH_DIVIDE: begin
        cls = itp_pkg::CL_OP;
        in_code = itp_pkg::OP_DIVIDE;
      end
      default: begin
        if (in_reg.in_char >= itp_pkg::CH_ZERO && in_reg.in_char <= itp_pkg::CH_NINE) begin
          cls = itp_pkg::CL_DIGIT;
        end else begin
          cls = itp_pkg::CL_ILLEGAL;
        end
      end
    endcase
  end

  assign final_code = (err == itp_pkg::ST_OK && !seen) ? itp_pkg::ST_EMPTY : err;
  assign push_code  = cmd.push_lparen ? itp_pkg::OP_LPAREN : in_code;

  always_comb begin
    emit_item = '0;
    case (cmd.emit_sel)
      itp_pkg::EM_CHAR:  emit_item.out_char = in_reg.in_char;
      itp_pkg::EM_TOP:   emit_item.out_char = itp_pkg::code_char(top_code);
      itp_pkg::EM_SPACE: emit_item.out_char = itp_pkg::CH_SPACE;
      default: begin
        emit_item.is_status   = 1'b1;
        emit_item.status_code = final_code;
      end
    endcase
  end

  always_comb begin
    sts.cls         = cls;
    sts.is_end      = in_reg.end_of_expression;
    sts.err_zero    = (err == itp_pkg::ST_OK);
    sts.dts         = dts;
    sts.pending     = pending;
    sts.seen        = seen;
    sts.stack_empty = (count == '0);
    sts.stack_full  = (count >= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
    sts.top_lparen  = (top_code == itp_pkg::OP_LPAREN);
    sts.pop_ok      = (top_code != itp_pkg::OP_LPAREN) &&
                      !(!itp_pkg::is_high(top_code) && itp_pkg::is_high(in_code));
    sts.can_emit    = !hold_valid || out_free;
    sts.hold_valid  = hold_valid;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_reg <= chr_data;
    end
    if (cmd.push) begin
      stack[count[itp_pkg::IDX_W-1:0]] <= push_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      seen        <= 1'b0;
      dts         <= 1'b0;
      after_digit <= 1'b0;
      pending     <= 1'b0;
      err         <= itp_pkg::ST_OK;
    end else if (cmd.clear_all) begin
      count       <= '0;
      seen        <= 1'b0;
      dts         <= 1'b0;
      after_digit <= 1'b0;
      pending     <= 1'b0;
      err         <= itp_pkg::ST_OK;
    end else begin
      if (cmd.pop) begin
        count <= count_m1;
      end else if (cmd.push) begin
        count <= count + 1'b1;
      end
      if (cmd.emit && cmd.emit_sel != itp_pkg::EM_STATUS) begin
        seen <= 1'b1;
      end
      if (cmd.fl_space && after_digit) begin
        dts <= 1'b1;
      end
      if (cmd.fl_digit) begin
        after_digit <= 1'b1;
      end
      if (cmd.fl_nondigit) begin
        after_digit <= 1'b0;
        dts         <= 1'b0;
      end
      if (cmd.fl_digit || cmd.clr_pending) begin
        pending <= 1'b0;
      end else if (cmd.set_pending) begin
        pending <= 1'b1;
      end
      if (cmd.set_err) begin
        err <= cmd.err_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      pfx_valid  <= 1'b0;
    end else begin
      if (cmd.emit) begin
        hold_valid <= 1'b1;
      end else if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
      if ((cmd.emit || cmd.flush) && hold_valid) begin
        pfx_valid <= 1'b1;
      end else if (pfx_ready) begin
        pfx_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hold <= emit_item;
    end
    if ((cmd.emit || cmd.flush) && hold_valid) begin
      pfx_data <= '{out_char:    hold.out_char,
                    is_status:   hold.is_status,
                    status_code: hold.status_code,
                    last_of_run: cmd.flush};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.flush) && hold_valid |-> out_free)
    else $error("Result moved to the output register while a transfer is pending.");

  assert property (@(posedge clk) disable iff (rst)
    count <= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH))
    else $error("Operator stack count exceeds its depth.");

  assert property (@(posedge clk) disable iff (rst)
    pfx_valid && pfx_data.is_status |-> pfx_data.last_of_run)
    else $error("Status result is not marked as the last of its run.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !cmd.pop && !sts.stack_full)
    else $error("Push onto a full stack or together with a pop.");

endmodule

FILE: src/itp_ctrl.sv
module itp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           chr_valid,
  output logic           chr_ready,
  input  itp_pkg::sts_t  sts,
  output itp_pkg::cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_DECODE    = 8'b0000_0010,
    S_POP_OP    = 8'b0000_0100,
    S_POP_PAREN = 8'b0000_1000,
    S_END       = 8'b0001_0000,
    S_DRAIN     = 8'b0010_0000,
    S_STATUS    = 8'b0100_0000,
    S_FLUSH     = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign chr_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (chr_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_end) begin
          state_next = S_END;
        end else if (!sts.err_zero) begin
          state_next = S_IDLE;
        end else begin
          case (sts.cls)
            itp_pkg::CL_SPACE: begin
              cmd.fl_space = 1'b1;
              state_next   = S_IDLE;
            end
            itp_pkg::CL_DIGIT: begin
              if (sts.dts) begin
                cmd.set_err  = 1'b1;
                cmd.err_code = itp_pkg::ST_SPACES;
                state_next   = S_IDLE;
              end else if (sts.can_emit) begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = itp_pkg::EM_CHAR;
                cmd.fl_digit = 1'b1;
                state_next   = S_FLUSH;
              end
            end
            itp_pkg::CL_LPAREN: begin
              cmd.fl_nondigit = 1'b1;
              cmd.clr_pending = 1'b1;
              if (sts.stack_full) begin
                cmd.set_err  = 1'b1;
                cmd.err_code = itp_pkg::ST_OVERFLOW;
              end else begin
                cmd.push        = 1'b1;
                cmd.push_lparen = 1'b1;
              end
              state_next = S_IDLE;
            end
            itp_pkg::CL_RPAREN: begin
              cmd.fl_nondigit = 1'b1;
              cmd.clr_pending = 1'b1;
              state_next      = S_POP_PAREN;
            end
            itp_pkg::CL_OP: begin
              cmd.fl_nondigit = 1'b1;
              if (!sts.seen || sts.pending) begin
                cmd.set_err  = 1'b1;
                cmd.err_code = itp_pkg::ST_OPERANDS;
                state_next   = S_IDLE;
              end else begin
                state_next = S_POP_OP;
              end
            end
            default: begin
              cmd.fl_nondigit = 1'b1;
              cmd.set_err     = 1'b1;
              cmd.err_code    = itp_pkg::ST_ILLEGAL;
              state_next      = S_IDLE;
            end
          endcase
        end
      end
      S_POP_OP: begin
        if (!sts.stack_empty && sts.pop_ok) begin
          if (sts.can_emit) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = itp_pkg::EM_TOP;
            cmd.pop      = 1'b1;
          end
        end else if (sts.stack_full) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = itp_pkg::ST_OVERFLOW;
          state_next   = S_FLUSH;
        end else if (sts.can_emit) begin
          cmd.push        = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_sel    = itp_pkg::EM_SPACE;
          cmd.set_pending = 1'b1;
          state_next      = S_FLUSH;
        end
      end
      S_POP_PAREN: begin
        if (sts.stack_empty) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = itp_pkg::ST_BRACES;
          state_next   = S_FLUSH;
        end else if (sts.top_lparen) begin
          cmd.pop    = 1'b1;
          state_next = S_FLUSH;
        end else if (sts.can_emit) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = itp_pkg::EM_TOP;
          cmd.pop      = 1'b1;
        end
      end
      S_END: begin
        if (sts.err_zero && sts.pending) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = itp_pkg::ST_OPERANDS;
          state_next   = S_STATUS;
        end else if (sts.err_zero) begin
          state_next = S_DRAIN;
        end else begin
          state_next = S_STATUS;
        end
      end
      S_DRAIN: begin
        if (sts.stack_empty) begin
          state_next = S_STATUS;
        end else if (sts.top_lparen) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = itp_pkg::ST_BRACES;
          state_next   = S_STATUS;
        end else if (sts.can_emit) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = itp_pkg::EM_TOP;
          cmd.pop      = 1'b1;
        end
      end
      S_STATUS: begin
        if (sts.can_emit) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = itp_pkg::EM_STATUS;
          cmd.clear_all = 1'b1;
          state_next    = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!sts.hold_valid) begin
          state_next = S_IDLE;
        end else if (sts.can_emit) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("Controller state is not one-hot.");

  assert property (@(posedge clk) disable iff (rst)
    state == S_DECODE |-> !sts.hold_valid)
    else $error("A result from the previous item is still held at decode.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.emit_sel == itp_pkg::EM_STATUS |=> state == S_FLUSH && sts.err_zero)
    else $error("Status result did not clear the error state.");

endmodule

FILE: src/infix_to_postfix_converter.sv
// Channel  Direction  Handshake              Payload
// chr      in         chr_valid / chr_ready  chr_data (itp_pkg::in_t)
// pfx      out        pfx_valid / pfx_ready  pfx_data (itp_pkg::out_t)
//
// An item is registered in the idle state, then decoded; a digit goes on to
// flush, an operator or ')' to its pop state and flush, the end marker to
// end, drain (skipped on an error), status and flush. Results leave one per
// cycle, when not stalled, via a hold stage in front of the output register.
// Reset is synchronous and clears the stack count, flags and error state.
// A stalled output transfer holds the controller wherever it must emit.
module infix_to_postfix_converter (
  input  logic           clk,
  input  logic           rst,
  input  logic           chr_valid,
  output logic           chr_ready,
  input  itp_pkg::in_t   chr_data,
  output logic           pfx_valid,
  input  logic           pfx_ready,
  output itp_pkg::out_t  pfx_data
);

  itp_pkg::cmd_t cmd;
  itp_pkg::sts_t sts;

  itp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  itp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .chr_data  (chr_data),
    .pfx_ready (pfx_ready),
    .pfx_valid (pfx_valid),
    .pfx_data  (pfx_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
